FILE: rtl/idht_pkg.sv
package idht_pkg;

  // slot count, a power of two so the home slot is the low bits of the hash
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int ID_BYTES = 16;
  localparam int BYTE_W   = $clog2(ID_BYTES);
  localparam int ID_W     = 8 * ID_BYTES;
  localparam int COUNT_W  = 7;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // low bits of a product depend only on low bits of its operands,
  // so the hash is kept only as wide as a slot index
  localparam logic [IDX_W-1:0] HASH_BASIS = FNV_BASIS[IDX_W-1:0];
  localparam logic [IDX_W-1:0] HASH_PRIME = FNV_PRIME[IDX_W-1:0];

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_INVAL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] page_in;
    logic [31:0] slot_in;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        page_out;
    logic [31:0]        slot_out;
    logic [COUNT_W-1:0] fill_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [31:0] page;
    logic [31:0] index;
  } entry_t;

  typedef struct packed {
    logic    ready;
    logic    load;
    logic    clear;
    logic    inval;
    logic    hash_step;
    logic    probe_rd;
    logic    probe_next;
    logic    write_ins;
    logic    write_upd;
    logic    res_set;
    logic    res_hit;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    usable;
    logic    hash_last;
    logic    occ;
    logic    key_match;
    logic    sweep_last;
    logic    out_free;
  } sts_t;

endpackage

FILE: rtl/idht_ctrl.sv
module idht_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  idht_pkg::action_t in_action,
  input  idht_pkg::sts_t   sts,
  output idht_pkg::cmd_t   cmd
);
  import idht_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_PRB  = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_action)
            ACT_CLEAR: begin
              cmd.clear   = 1'b1;
              cmd.res_set = 1'b1;
              state_nxt   = S_DONE;
            end
            ACT_INVAL: begin
              cmd.inval   = 1'b1;
              cmd.res_set = 1'b1;
              state_nxt   = S_DONE;
            end
            ACT_LOOKUP: begin
              if (!sts.usable) begin
                cmd.res_set  = 1'b1;
                cmd.res_code = ST_MISS;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_HASH;
              end
            end
            default: state_nxt = S_HASH;
          endcase
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) state_nxt = S_PRB;
      end
      S_PRB: begin
        if (!sts.occ) begin
          cmd.res_set = 1'b1;
          if (sts.action == ACT_INSERT) begin
            cmd.write_ins = 1'b1;
          end else begin
            cmd.res_code = ST_MISS;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.probe_rd = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.res_set = 1'b1;
          if (sts.action == ACT_INSERT) begin
            cmd.write_upd = 1'b1;
          end else begin
            cmd.res_hit = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (sts.sweep_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = (sts.action == ACT_INSERT) ? ST_FULL : ST_MISS;
          state_nxt    = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PRB;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/idht_dp.sv
module idht_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  idht_pkg::in_item_t in_data,
  input  logic               out_stall,
  input  idht_pkg::cmd_t     cmd,
  output idht_pkg::sts_t     sts,
  output logic               out_valid,
  output idht_pkg::out_item_t out_data
);
  import idht_pkg::*;

  in_item_t           item_r;
  logic [IDX_W-1:0]   h_r;
  logic [IDX_W-1:0]   h_nxt;
  logic [IDX_W-1:0]   h_mix;
  logic [BYTE_W-1:0]  byte_r;
  logic [IDX_W-1:0]   prb_cnt_r;
  logic [ID_W-1:0]    id_cat;
  logic [7:0]         id_byte;

  logic [CAPACITY-1:0] occ_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic                usable_r;

  entry_t mem [CAPACITY];
  entry_t rd_q;
  entry_t wr_entry;

  status_t     res_status_r;
  logic [31:0] res_page_r;
  logic [31:0] res_slot_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // byte 0 sits at the top of the id
  assign id_cat  = {item_r.id_high, item_r.id_low};
  assign id_byte = id_cat[{~byte_r, 3'b000} +: 8];
  assign h_mix   = h_r ^ IDX_W'(id_byte);
  assign h_nxt   = IDX_W'(h_mix * HASH_PRIME);

  assign wr_entry = '{key_high: item_r.id_high, key_low: item_r.id_low,
                      page: item_r.page_in, index: item_r.slot_in};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r    <= in_data;
      h_r       <= HASH_BASIS;
      byte_r    <= '0;
      prb_cnt_r <= '0;
    end else if (cmd.hash_step) begin
      h_r    <= h_nxt;
      byte_r <= byte_r + BYTE_W'(1);
    end else if (cmd.probe_next) begin
      h_r       <= h_r + IDX_W'(1);
      prb_cnt_r <= prb_cnt_r + IDX_W'(1);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_page_r   <= cmd.res_hit ? rd_q.page  : 32'd0;
      res_slot_r   <= cmd.res_hit ? rd_q.index : 32'd0;
    end
    if (cmd.out_load) begin
      out_data_r <= '{status: res_status_r, page_out: res_page_r,
                      slot_out: res_slot_r, fill_count: cnt_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_ins || cmd.write_upd) mem[h_r] <= wr_entry;
    if (cmd.probe_rd) rd_q <= mem[h_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cnt_r       <= '0;
      usable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        occ_r    <= '0;
        cnt_r    <= '0;
        usable_r <= 1'b1;
      end else if (cmd.inval) begin
        usable_r <= 1'b0;
      end else if (cmd.write_ins) begin
        occ_r[h_r] <= 1'b1;
        cnt_r      <= cnt_r + COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.action     = item_r.action;
  assign sts.usable     = usable_r;
  assign sts.hash_last  = (byte_r == BYTE_W'(ID_BYTES - 1));
  assign sts.occ        = occ_r[h_r];
  assign sts.key_match  = (rd_q.key_high == item_r.id_high) &&
                          (rd_q.key_low == item_r.id_low);
  assign sts.sweep_last = (prb_cnt_r == IDX_W'(CAPACITY - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/id_hash_table_linear_probe_core.sv
// latency: clear, invalidate and a lookup on an unusable table load the output register
//   1 cycle after the accepting edge; lookup and insert take 17 + 2 * slots read, +1 when
//   the probe ends at an empty slot (16 hash cycles, then a test and a compare per slot)
// throughput: one beat in flight; the next beat is taken the cycle after the result moves
//   into the output register, and that move waits while a held result is stalled
// reset: synchronous active-low rst_n empties all slots, zeroes the count, table unusable
module id_hash_table_linear_probe_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  idht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output idht_pkg::out_item_t out_data
);
  import idht_pkg::*;

  // controller to datapath commands and status flags
  cmd_t cmd;
  sts_t sts;

  // input beats are taken only while the controller sits idle
  assign in_stall = !cmd.ready;

  // sequencing: accept, hash, probe loop, hand result to output register
  idht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash unit, probe index, entry memory, occupancy flops and output register
  idht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a taken beat always closes the input side on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous beat still in flight");

  // page and slot are only reported on a hit
  a_zero_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.page_out == 32'd0) && (out_data.slot_out == 32'd0))
    else $error("page or slot reported without a hit");

  // a full report means every slot is occupied
  a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |->
      out_data.fill_count == COUNT_W'(CAPACITY))
    else $error("table full reported with free slots");

  // a result beat is never offered while the controller is idle and nothing was done
  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_stall) == 1'b0)
    else $error("result appeared without an item in flight");
`endif

endmodule
